// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the record table RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define ASSERT_ON_CLK(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error(msg);

// Concurrent check on the module's own clk and rst_n.
`define ASSERT_LOCAL(lbl, prop, msg) `ASSERT_ON_CLK(lbl, clk, rst_n, prop, msg)

`endif

// ===== rtl/ckrt_pkg.sv =====
// Shared constants, codes and control/status structs for the record table.
// No dependencies.
`timescale 1ns / 1ps

package ckrt_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int KEY_BYTES = 7;
    localparam int KEY_W     = KEY_BYTES * 8;
    localparam int TIME_W    = 32;
    localparam int LEVEL_W   = 3;
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int INDEX_W   = 7;
    localparam int COUNT_W   = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_FIND   = 2'd1,
        ACT_DELETE = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    // Source of the reported slot index.
    typedef enum logic [1:0] {
        IDX_ZERO  = 2'd0,
        IDX_COUNT = 2'd1,
        IDX_SCAN  = 2'd2
    } idx_sel_t;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_DECODE   = 3'd1,
        S_ADD_WR   = 3'd2,
        S_SCAN_RD  = 3'd3,
        S_SCAN_CMP = 3'd4,
        S_SHIFT_RD = 3'd5,
        S_SHIFT_WR = 3'd6,
        S_FINISH   = 3'd7
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [TIME_W-1:0]  entry_time;
        logic [TIME_W-1:0]  park_time;
        logic [LEVEL_W-1:0] level;
    } record_t;

    typedef struct packed {
        logic     capture;
        logic     idx_clear;
        logic     idx_inc;
        logic     rd_en;
        logic     rd_next;
        logic     wr_add;
        logic     wr_shift;
        logic     count_inc;
        logic     count_dec;
        logic     set_result;
        status_t  res_status;
        idx_sel_t res_sel;
        logic     res_load;
    } cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                full;
        logic                scan_end;
        logic                shift_end;
        logic                key_hit;
    } stat_t;

endpackage

// ===== rtl/ckrt_ctrl.sv =====
// Sequencer for add, find and delete: drives datapath commands and the result valid.
// Depends on ckrt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ckrt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    input  ckrt_pkg::stat_t stat,
    output ckrt_pkg::cmd_t  cmd
);

    import ckrt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        if (cmd.res_load)
            out_valid_next = 1'b1;
        else if (!rsp_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                priority if (stat.action == ACT_ADD)
                    state_next = stat.full ? S_FINISH : S_ADD_WR;
                else if (stat.action == ACT_FIND || stat.action == ACT_DELETE)
                    state_next = S_SCAN_RD;
                else
                    state_next = S_FINISH;
            end
            S_ADD_WR:
                state_next = S_FINISH;
            S_SCAN_RD:
                state_next = stat.scan_end ? S_FINISH : S_SCAN_CMP;
            S_SCAN_CMP:
            begin
                priority if (!stat.key_hit)
                    state_next = S_SCAN_RD;
                else if (stat.action == ACT_DELETE)
                    state_next = S_SHIFT_RD;
                else
                    state_next = S_FINISH;
            end
            S_SHIFT_RD:
                state_next = stat.shift_end ? S_FINISH : S_SHIFT_WR;
            S_SHIFT_WR:
                state_next = S_SHIFT_RD;
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture   = req_valid;
                cmd.idx_clear = req_valid;
            end
            S_DECODE:
            begin
                priority if (stat.action == ACT_ADD)
                begin
                    if (stat.full)
                    begin
                        cmd.set_result = 1'b1;
                        cmd.res_status = STAT_FULL;
                        cmd.res_sel    = IDX_ZERO;
                    end
                end
                else if (stat.action == ACT_FIND || stat.action == ACT_DELETE)
                begin
                    cmd.idx_clear = 1'b1;
                end
                else
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = STAT_OK;
                    cmd.res_sel    = IDX_ZERO;
                end
            end
            S_ADD_WR:
            begin
                cmd.wr_add     = 1'b1;
                cmd.count_inc  = 1'b1;
                cmd.set_result = 1'b1;
                cmd.res_status = STAT_OK;
                cmd.res_sel    = IDX_COUNT;
            end
            S_SCAN_RD:
            begin
                if (stat.scan_end)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = STAT_NOT_FOUND;
                    cmd.res_sel    = IDX_ZERO;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                end
            end
            S_SCAN_CMP:
            begin
                if (stat.key_hit)
                begin
                    // hold idx at the match: the shift starts there
                    cmd.set_result = 1'b1;
                    cmd.res_status = STAT_OK;
                    cmd.res_sel    = IDX_SCAN;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SHIFT_RD:
            begin
                if (stat.shift_end)
                    cmd.count_dec = 1'b1;
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
            end
            S_FINISH:
                cmd.res_load = out_free;
            default:
                cmd = '0;
        endcase
    end

    `ASSERT_LOCAL(a_no_overwrite,
        (state_reg == S_FINISH && out_valid_reg && rsp_stall) |=> (state_reg == S_FINISH),
        "pending result overwritten while stalled")
    `ASSERT_LOCAL(a_cmp_after_read,
        (state_reg == S_SCAN_CMP) |-> ($past(state_reg) == S_SCAN_RD),
        "key compare without a preceding read")
    `ASSERT_LOCAL(a_rsp_hold,
        (out_valid_reg && rsp_stall) |=> out_valid_reg,
        "result dropped while stalled")

endmodule

// ===== rtl/ckrt_dp.sv =====
// Record table datapath: record memory, counters, key compare and result registers.
// Depends on ckrt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ckrt_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [ckrt_pkg::ACTION_W-1:0]    action,
    input  logic [ckrt_pkg::KEY_W-1:0]       plate_key,
    input  logic [ckrt_pkg::TIME_W-1:0]      entry_time,
    input  logic [ckrt_pkg::TIME_W-1:0]      park_time,
    input  logic [ckrt_pkg::LEVEL_W-1:0]     level,
    input  ckrt_pkg::cmd_t                   cmd,
    output ckrt_pkg::stat_t                  stat,
    output logic [ckrt_pkg::STATUS_W-1:0]    status,
    output logic [ckrt_pkg::INDEX_W-1:0]     match_index,
    output logic [ckrt_pkg::COUNT_W-1:0]     entry_count
);

    import ckrt_pkg::*;

    record_t             rec_mem [TABLE_ENTRIES];
    record_t             op_rec_reg;
    logic [ACTION_W-1:0] op_action_reg;
    record_t             rd_data_reg;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    idx_next;
    logic [CNT_W-1:0]    idx_plus1;

    status_t             pend_status_reg;
    logic [ADDR_W-1:0]   pend_index_reg;
    logic [ADDR_W-1:0]   pend_index_next;
    status_t             status_reg;
    logic [INDEX_W-1:0]  match_index_reg;
    logic [COUNT_W-1:0]  entry_count_reg;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    record_t             wr_data;
    logic [ADDR_W-1:0]   rd_addr;

    assign idx_plus1 = idx_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_inc)
            count_next = count_reg + 1'b1;
        else if (cmd.count_dec)
            count_next = count_reg - 1'b1;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_clear)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_plus1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Record memory: one write port, one registered read port
    assign wr_en   = cmd.wr_add || cmd.wr_shift;
    assign wr_addr = cmd.wr_add ? count_reg[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign wr_data = cmd.wr_add ? op_rec_reg : rd_data_reg;
    assign rd_addr = cmd.rd_next ? idx_plus1[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            rec_mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= rec_mem[rd_addr];
    end

    always_comb
    begin
        unique case (cmd.res_sel)
            IDX_COUNT: pend_index_next = count_reg[ADDR_W-1:0];
            IDX_SCAN:  pend_index_next = idx_reg[ADDR_W-1:0];
            default:   pend_index_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_action_reg         <= action;
            op_rec_reg.key        <= plate_key;
            op_rec_reg.entry_time <= entry_time;
            op_rec_reg.park_time  <= park_time;
            op_rec_reg.level      <= level;
        end
        if (cmd.set_result)
        begin
            pend_status_reg <= cmd.res_status;
            pend_index_reg  <= pend_index_next;
        end
        if (cmd.res_load)
        begin
            status_reg      <= pend_status_reg;
            match_index_reg <= INDEX_W'(pend_index_reg);
            entry_count_reg <= COUNT_W'(count_reg);
        end
    end

    assign stat.action    = op_action_reg;
    assign stat.full      = (count_reg == CNT_W'(TABLE_ENTRIES));
    assign stat.scan_end  = (idx_reg == count_reg);
    assign stat.shift_end = (idx_plus1 == count_reg);
    assign stat.key_hit   = (rd_data_reg.key == op_rec_reg.key);

    assign status      = status_reg;
    assign match_index = match_index_reg;
    assign entry_count = entry_count_reg;

    `ASSERT_LOCAL(a_add_room,
        cmd.wr_add |-> (count_reg < CNT_W'(TABLE_ENTRIES)),
        "add write into a full table")
    `ASSERT_LOCAL(a_scan_range,
        (cmd.rd_en && !cmd.rd_next) |-> (idx_reg < count_reg),
        "scan read beyond stored records")
    `ASSERT_LOCAL(a_dec_nonempty,
        cmd.count_dec |-> (count_reg != '0 && idx_plus1 == count_reg),
        "delete on empty table or before shift end")

endmodule

// ===== rtl/compacting_keyed_record_table_top.sv =====
// Path from acceptance to rsp_valid high: add runs S_DECODE, S_ADD_WR, S_FINISH; a full add or
// unused code runs S_DECODE, S_FINISH; find reads and compares each slot from slot 0 in turn;
// delete then shifts each later record down one slot; S_FINISH waits out a stalled result.
// One item at a time: the next request is accepted from the cycle in which rsp_valid rises.
// Reset: rst_n clears the count and control at once; records need no clearing pass.
// Top level: ties the sequencer to the record datapath. Depends on ckrt_pkg.
`timescale 1ns / 1ps

module compacting_keyed_record_table_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [ckrt_pkg::ACTION_W-1:0] action,
    input  logic [ckrt_pkg::KEY_W-1:0]    plate_key,
    input  logic [ckrt_pkg::TIME_W-1:0]   entry_time,
    input  logic [ckrt_pkg::TIME_W-1:0]   park_time,
    input  logic [ckrt_pkg::LEVEL_W-1:0]  level,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [ckrt_pkg::STATUS_W-1:0] status,
    output logic [ckrt_pkg::INDEX_W-1:0]  match_index,
    output logic [ckrt_pkg::COUNT_W-1:0]  entry_count
);

    import ckrt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    ckrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ckrt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .action      (action),
        .plate_key   (plate_key),
        .entry_time  (entry_time),
        .park_time   (park_time),
        .level       (level),
        .cmd         (cmd),
        .stat        (stat),
        .status      (status),
        .match_index (match_index),
        .entry_count (entry_count)
    );

endmodule
